>>> hdl/lpht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and hash function for the linear-probing table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int KEY_W    = 64;
  localparam int VALUE_PW = 32;
  localparam int COUNT_PW = 9;

  localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic step;
    logic wr_key;
    logic wr_val;
    logic cnt_inc;
    logic fin;
    logic fin_ok;
    logic fin_rd;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic mode_ins;
    logic slot_empty;
    logic slot_hit;
    logic probe_wrap;
    logic clr_last;
  } sts_t;

  // FNV-1a over a single byte. Only used at elaboration to build the home-slot table.
  function automatic logic [63:0] fnv_byte(input logic [7:0] b);
    logic [63:0] h;
    h = HASH_BASIS ^ {56'd0, b};
    return h * HASH_PRIME;
  endfunction

endpackage
`default_nettype wire

>>> hdl/linear_probe_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressed key/value table with linear probing on a one-byte FNV-1a hash.
// ----------------------------------------------------------------------------
// A rejected item (zero key, or zero value on insert) answers in the cycle after
// its transfer; any other item probes slot by slot from its home slot, with one
// read and one compare per slot, until a hit, an empty slot or a full turn, so up
// to TABLE_SIZE slots. busy drops with the done strobe: no new item until it answers.
// After reset a clearing pass zeroes the key memory with busy high.
// The receiver cannot stall: done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int TABLE_SIZE  = lpht_pkg::TABLE_SIZE_DEF,
  parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key,
  input  wire logic [lpht_pkg::VALUE_PW-1:0] value,
  output logic                               done,
  output logic                               ok,
  output logic [lpht_pkg::VALUE_PW-1:0]      read_value,
  output logic [lpht_pkg::COUNT_PW-1:0]      entry_count
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lpht_dpath #(
    .TABLE_SIZE  (TABLE_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .ok          (ok),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

endmodule
`default_nettype wire

>>> hdl/lpht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: clearing pass after reset, then probe sequencing per item.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t      cmd,
  output logic               busy
);

  lpht_pkg::state_t state;
  lpht_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      lpht_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = lpht_pkg::ST_IDLE;
        end
      end
      lpht_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (sts.reject) begin
            // Zero key or zero insert value: answer at once with a miss.
            cmd.fin = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = lpht_pkg::ST_READ;
          end
        end
      end
      lpht_pkg::ST_READ: begin
        state_next = lpht_pkg::ST_CHECK;
      end
      lpht_pkg::ST_CHECK: begin
        state_next = lpht_pkg::ST_IDLE;
        if (sts.slot_hit) begin
          cmd.fin    = 1'b1;
          cmd.fin_ok = 1'b1;
          if (sts.mode_ins) begin
            cmd.wr_val = 1'b1;
          end else begin
            cmd.fin_rd = 1'b1;
          end
        end else if (sts.slot_empty) begin
          cmd.fin = 1'b1;
          if (sts.mode_ins) begin
            cmd.wr_key  = 1'b1;
            cmd.wr_val  = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.fin_ok  = 1'b1;
          end
        end else if (sts.probe_wrap) begin
          // Came back to the home slot: the table is full.
          cmd.fin = 1'b1;
        end else begin
          cmd.step   = 1'b1;
          state_next = lpht_pkg::ST_READ;
        end
      end
      default: begin
        state_next = lpht_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/lpht_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_dpath
// Datapath: home-slot table, key and value memories, probe index, count and
// result registers.
// ----------------------------------------------------------------------------
module lpht_dpath #(
  parameter int TABLE_SIZE  = lpht_pkg::TABLE_SIZE_DEF,
  parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          mode,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key,
  input  wire logic [lpht_pkg::VALUE_PW-1:0] value,
  input  wire lpht_pkg::cmd_t                cmd,
  output lpht_pkg::sts_t                     sts,
  output logic                               done,
  output logic                               ok,
  output logic [lpht_pkg::VALUE_PW-1:0]      read_value,
  output logic [lpht_pkg::COUNT_PW-1:0]      entry_count
);

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

  // Home slot for every possible low key byte, fixed at elaboration.
  logic [AW-1:0] home_lut [256];

  for (genvar b = 0; b < 256; b++) begin : g_home
    localparam logic [63:0] H = lpht_pkg::fnv_byte(8'(b));
    assign home_lut[b] = AW'(H % 64'(TABLE_SIZE));
  end

  logic [lpht_pkg::KEY_W-1:0] key_mem [TABLE_SIZE];
  logic [VALUE_WIDTH-1:0]     val_mem [TABLE_SIZE];

  logic [lpht_pkg::KEY_W-1:0] key_r;
  logic [VALUE_WIDTH-1:0]     val_r;
  logic                       mode_r;
  logic [AW-1:0]              idx;
  logic [AW-1:0]              start_idx;
  logic [AW-1:0]              idx_inc;
  logic [AW-1:0]              clr_idx;
  logic [CW-1:0]              count;
  logic [lpht_pkg::KEY_W-1:0] rd_key;
  logic [VALUE_WIDTH-1:0]     rd_val;
  logic [63:0]                val_ext;
  logic [VALUE_WIDTH-1:0]     val_in;
  logic [63:0]                rd_ext;

  function automatic logic [AW-1:0] idx_clr_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  assign val_ext = {32'd0, value};
  assign val_in  = val_ext[VALUE_WIDTH-1:0];
  assign rd_ext  = 64'(rd_val);
  assign idx_inc = (idx == LAST_IDX) ? '0 : idx + AW'(1);

  assign sts.reject     = (key == '0) || (mode && (val_in == '0));
  assign sts.mode_ins   = mode_r;
  assign sts.slot_empty = (rd_key == '0);
  assign sts.slot_hit   = (rd_key == key_r);
  assign sts.probe_wrap = (idx_inc == start_idx);
  assign sts.clr_last   = (clr_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= key;
      val_r     <= val_in;
      mode_r    <= mode;
      idx       <= home_lut[key[7:0]];
      start_idx <= home_lut[key[7:0]];
    end else if (cmd.step) begin
      idx <= idx_inc;
    end
  end

  // The key memory shares its write port between the clearing pass and inserts.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      key_mem[clr_idx] <= '0;
    end else if (cmd.wr_key) begin
      key_mem[idx] <= key_r;
    end
    rd_key <= key_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_val) begin
      val_mem[idx] <= val_r;
    end
    rd_val <= val_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= idx_clr_next(clr_idx);
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      ok         <= cmd.fin_ok;
      read_value <= cmd.fin_rd ? rd_ext[lpht_pkg::VALUE_PW-1:0] : '0;
    end
  end

  assign entry_count = lpht_pkg::COUNT_PW'(count);

endmodule
`default_nettype wire

>>> tb/lpht_tb_pkg.sv
// ----------------------------------------------------------------------------
// lpht_tb_pkg
// Access codes shared by the hash table testbench and its checker.
// ----------------------------------------------------------------------------
package lpht_tb_pkg;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_INSERT = 1'b1
  } access_mode_t;

endpackage

>>> tb/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the command and result ports of the hash table, keeps its own copy
// of the key and value stores, and compares every result in order.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
  import lpht_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                mode,
  input  logic [KEY_W-1:0]    key,
  input  logic [VALUE_PW-1:0] value,
  input  logic                done,
  input  logic                ok,
  input  logic [VALUE_PW-1:0] read_value,
  input  logic [COUNT_PW-1:0] entry_count,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = TABLE_SIZE_DEF;

  typedef struct packed {
    logic                ok;
    logic [VALUE_PW-1:0] rd;
    logic [COUNT_PW-1:0] cnt;
  } table_reply_t;

  logic [KEY_W-1:0]    slot_key [SLOTS];
  logic [VALUE_PW-1:0] slot_val [SLOTS];
  int                  fill_count;
  table_reply_t        pending_replies[$];
  int                  fail_count;
  int                  reply_index;

  function automatic int home_slot(input logic [KEY_W-1:0] k);
    logic [63:0] h;
    h = (HASH_BASIS ^ {56'd0, k[7:0]}) * HASH_PRIME;
    return int'(h % 64'(SLOTS));
  endfunction

  // Applies one access to the local table copy and returns the reply it earns.
  function automatic table_reply_t table_access(input logic m, input logic [KEY_W-1:0] k,
                                                input logic [VALUE_PW-1:0] v);
    table_reply_t r;
    int           first;
    int           idx;
    bit           hit;
    bit           has_empty;
    r = '0;
    hit = 1'b0;
    has_empty = 1'b0;
    first = home_slot(k);
    idx = first;
    if (k != '0 && (m == MODE_LOOKUP || v != '0)) begin
      while (slot_key[idx] != '0) begin
        if (slot_key[idx] == k) begin
          hit = 1'b1;
          break;
        end
        idx = (idx + 1) % SLOTS;
        if (idx == first) break;
      end
      has_empty = !hit && slot_key[idx] == '0;
      if (m == MODE_LOOKUP) begin
        if (hit) begin
          r.ok = 1'b1;
          r.rd = slot_val[idx];
        end
      end else if (hit) begin
        slot_val[idx] = v;
        r.ok = 1'b1;
      end else if (has_empty) begin
        slot_key[idx] = k;
        slot_val[idx] = v;
        fill_count++;
        r.ok = 1'b1;
      end
    end
    r.cnt = fill_count[COUNT_PW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      fill_count = 0;
      fail_count = 0;
      reply_index = 0;
      pending_replies.delete();
    end else begin
      if (done) begin
        if (pending_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no transfer pending: ok=%0b read_value=%h entry_count=%0d",
                     $realtime, ok, read_value, entry_count);
        end else begin
          want = pending_replies.pop_front();
          if (ok !== want.ok || read_value !== want.rd || entry_count !== want.cnt) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: result %0d: expected ok=%0b read_value=%h entry_count=%0d,",
                        " got ok=%0b read_value=%h entry_count=%0d"},
                       $realtime, reply_index, want.ok, want.rd, want.cnt,
                       ok, read_value, entry_count);
          end
        end
        reply_index++;
      end
      if (start && !busy) pending_replies.push_back(table_access(mode, key, value));
    end
    mismatches <= fail_count;
    outstanding <= pending_replies.size();
  end

endmodule

>>> tb/linear_probe_hash_table_core_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core_tb
// Drives lookups and inserts into the hash table: directed corner cases, then
// random traffic that fills the table from a clustered key pool and keeps
// working on it once it is full. A checker module predicts every result.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core_tb;
  import lpht_pkg::*;
  import lpht_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = TABLE_SIZE_DEF;
  localparam int POOL_SIZE     = 320;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int DRAIN_CYCLES  = 2 * SLOTS + 8;
  localparam int MAX_IDLE_RUN  = 48;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                mode;
  logic [KEY_W-1:0]    key;
  logic [VALUE_PW-1:0] value;
  logic                done;
  logic                ok;
  logic [VALUE_PW-1:0] read_value;
  logic [COUNT_PW-1:0] entry_count;
  int                  mismatches;
  int                  outstanding;
  int                  quiet_cycles;
  int                  sent_count;
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];
  logic [7:0]          hot_bytes [8];
  int                  idle_pct_by_phase [3] = '{0, 88, 18};

  linear_probe_hash_table_core DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .done        (done),
    .ok          (ok),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  lpht_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .done        (done),
    .ok          (ok),
    .read_value  (read_value),
    .entry_count (entry_count),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Any transfer in either direction counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Idle stretches rotate between none, heavy and light every 60 transfers.
  task automatic send_request(input logic m, input logic [KEY_W-1:0] k,
                              input logic [VALUE_PW-1:0] v);
    int pct;
    int gap;
    pct = idle_pct_by_phase[(sent_count / 60) % 3];
    gap = 0;
    while ($urandom_range(99) < pct && gap < MAX_IDLE_RUN) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    value <= v;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic random_request(input int pool_limit, input int insert_pct);
    logic [KEY_W-1:0]    k;
    logic [VALUE_PW-1:0] v;
    int                  sel;
    sel = $urandom_range(99);
    if (sel < 5) k = '0;
    else if (sel < 15) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(pool_limit)];
    v = ($urandom_range(99) < 5) ? '0 : $urandom;
    send_request(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_LOOKUP, k, v);
  endtask

  initial begin
    logic [VALUE_PW-1:0] v;
    rst   <= 1'b1;
    start <= 1'b0;
    mode  <= MODE_LOOKUP;
    key   <= '0;
    value <= '0;
    sent_count = 0;

    // About half of the pool shares a few low bytes, so home slots pile up and wrap.
    foreach (hot_bytes[i]) hot_bytes[i] = 8'($urandom);
    hot_bytes[0] = 8'hff;
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][7:0] = $urandom_range(1) ? hot_bytes[$urandom_range(7)]
                                           : 8'($urandom_range(255));
      if (key_pool[i] == '0) key_pool[i][63] = 1'b1;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Rejections and a miss on the empty table.
    send_request(MODE_LOOKUP, '0, 32'h1234_5678);
    send_request(MODE_INSERT, '0, 32'h0000_0005);
    send_request(MODE_INSERT, 64'h0123_4567_89ab_cdef, '0);
    send_request(MODE_LOOKUP, 64'h0123_4567_89ab_cdef, '0);
    // Extreme key and value, then an update of the same key.
    send_request(MODE_INSERT, '1, '1);
    send_request(MODE_LOOKUP, '1, '0);
    send_request(MODE_INSERT, '1, 32'h0000_0001);
    send_request(MODE_LOOKUP, '1, 32'hffff_ffff);
    // Keys sharing a low byte land in the same home slot and probe onward.
    send_request(MODE_INSERT, 64'h0000_0000_0000_0001, 32'h8000_0000);
    send_request(MODE_INSERT, 64'h8000_0000_0000_0001, 32'h5555_5555);
    send_request(MODE_INSERT, 64'h0000_0001_0000_0001, 32'haaaa_aaaa);
    send_request(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
    send_request(MODE_LOOKUP, 64'h0000_0001_0000_0001, '0);
    send_request(MODE_LOOKUP, 64'h0000_0000_0000_0001, '0);
    send_request(MODE_LOOKUP, 64'h7fff_ffff_ffff_ff01, '0);
    send_request(MODE_INSERT, 64'h8000_0000_0000_0001, '0);
    send_request(MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
    send_request(MODE_INSERT, 64'hffff_ffff_ffff_ff00, 32'h7fff_ffff);
    send_request(MODE_LOOKUP, 64'hffff_ffff_ffff_ff00, '0);
    send_request(MODE_LOOKUP, 64'h0000_0000_0000_0100, '0);

    // Mixed traffic over a slowly widening slice of the pool.
    for (int n = 0; n < 275; n++) random_request(24 + n / 2, 60);

    // Let the table drain completely before the fill sweep. The checker's
    // count of pending results is registered, so it lags the last transfer.
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    // Insert every pool key: more keys than slots, so the last ones fail.
    for (int i = 0; i < POOL_SIZE; i++) begin
      v = $urandom;
      if (v == '0) v = 32'h0000_0001;
      send_request(MODE_INSERT, key_pool[i], v);
    end

    // Traffic on the full table: hits, full-turn misses and failed inserts.
    for (int n = 0; n < 250; n++) random_request(POOL_SIZE - 1, 40);

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lpht_pkg.sv
hdl/lpht_ctrl.sv
hdl/lpht_dpath.sv
hdl/linear_probe_hash_table_core.sv
tb/lpht_tb_pkg.sv
tb/lpht_checker.sv
tb/linear_probe_hash_table_core_tb.sv
